/* rtl/core/jsu_pkg.sv */
`default_nettype none

package jsu_pkg;

    // Depth of the command queue between front and back
    localparam int JSU_QUEUE_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_QUOTE  = 2'd0;
    localparam logic [1:0] ERR_ESCAPE = 2'd1;
    localparam logic [1:0] ERR_HEX    = 2'd2;
    localparam logic [1:0] ERR_ENDED  = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic [1:0] error_code;
        logic       last_of_run;
    } out_item_t;

    // What the back end has to emit for one input byte
    typedef enum logic [1:0] {
        OP_DATA,
        OP_UTF8,
        OP_DONE,
        OP_ERROR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [15:0] value;
        logic [1:0]  err_code;
        logic        ended;
    } cmd_t;

    // Queue status seen by the top level and the back end
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Number of UTF-8 bytes for a code point, 1 to 3
    function automatic logic [1:0] utf8_len(input logic [15:0] cp);
        logic [1:0] len;
        if (cp < 16'h0080) begin
            len = 2'd1;
        end else if (cp < 16'h0800) begin
            len = 2'd2;
        end else begin
            len = 2'd3;
        end
        return len;
    endfunction

    // Byte number idx of the UTF-8 form of a code point
    function automatic logic [7:0] utf8_byte(input logic [15:0] cp, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (utf8_len(cp))
            2'd1: b = cp[7:0];
            2'd2: b = (idx == 2'd0) ? (8'hC0 | {3'b000, cp[10:6]})
                                    : (8'h80 | {2'b00, cp[5:0]});
            default: begin
                case (idx)
                    2'd0:    b = 8'hE0 | {4'h0, cp[15:12]};
                    2'd1:    b = 8'h80 | {2'b00, cp[11:6]};
                    default: b = 8'h80 | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/jsu_front.sv */
`default_nettype none

module jsu_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire jsu_pkg::in_item_t in_word,
    output jsu_pkg::cmd_t         cmd,
    output logic                  push
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX,
        MODE_DROP
    } mode_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_U     = 8'h75;

    // Decode one hex digit: {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Map a simple escape letter: {valid, byte}
    function automatic logic [8:0] esc_map(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_QUOTE: r = {1'b1, CH_QUOTE};
            CH_BSL:   r = {1'b1, CH_BSL};
            CH_SLASH: r = {1'b1, CH_SLASH};
            8'h62:    r = {1'b1, 8'h08};
            8'h66:    r = {1'b1, 8'h0C};
            8'h6E:    r = {1'b1, 8'h0A};
            8'h72:    r = {1'b1, 8'h0D};
            8'h74:    r = {1'b1, 8'h09};
            default:  r = 9'd0;
        endcase
        return r;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;

    logic [7:0]  c;
    logic        last;
    logic [4:0]  hd;
    logic [8:0]  em;
    logic        has_main;
    logic        failed;
    cmd_t        cmd_c;

    assign c    = in_word.in_byte;
    assign last = in_word.end_of_text;
    assign hd   = hex_digit(c);
    assign em   = esc_map(c);

    // Classify the byte against the current scan mode
    always_comb
    begin
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        has_main       = 1'b0;
        failed         = 1'b0;
        cmd_c.op       = OP_ERROR;
        cmd_c.value    = 16'h0000;
        cmd_c.err_code = ERR_ENDED;
        cmd_c.ended    = 1'b0;

        case (mode_reg)
            MODE_STR: begin
                if (c == CH_QUOTE) begin
                    has_main  = 1'b1;
                    cmd_c.op  = OP_DONE;
                    mode_next = MODE_IDLE;
                end else if (c == CH_BSL) begin
                    mode_next = MODE_ESC;
                end else begin
                    has_main    = 1'b1;
                    cmd_c.op    = OP_DATA;
                    cmd_c.value = {8'h00, c};
                end
            end
            MODE_ESC: begin
                if (em[8]) begin
                    has_main    = 1'b1;
                    cmd_c.op    = OP_DATA;
                    cmd_c.value = {8'h00, em[7:0]};
                    mode_next   = MODE_STR;
                end else if (c == CH_U) begin
                    cnt_next  = 2'd0;
                    acc_next  = 16'h0000;
                    mode_next = MODE_HEX;
                end else begin
                    has_main       = 1'b1;
                    failed         = 1'b1;
                    cmd_c.err_code = ERR_ESCAPE;
                end
            end
            MODE_HEX: begin
                if (!hd[4]) begin
                    has_main       = 1'b1;
                    failed         = 1'b1;
                    cmd_c.err_code = ERR_HEX;
                end else if (cnt_reg == 2'd3) begin
                    has_main    = 1'b1;
                    cmd_c.op    = OP_UTF8;
                    cmd_c.value = {acc_reg[11:0], hd[3:0]};
                    cnt_next    = 2'd0;
                    acc_next    = 16'h0000;
                    mode_next   = MODE_STR;
                end else begin
                    acc_next = {acc_reg[11:0], hd[3:0]};
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            MODE_DROP: begin
                if (last) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                if (c == CH_QUOTE) begin
                    mode_next = MODE_STR;
                end else if (c == CH_SPACE || (c inside {[8'h09:8'h0D]})) begin
                    mode_next = MODE_IDLE;
                end else begin
                    has_main       = 1'b1;
                    failed         = 1'b1;
                    cmd_c.err_code = ERR_QUOTE;
                end
            end
        endcase

        // Drop into error recovery, or close an unfinished string at end of text
        if (failed) begin
            mode_next = last ? MODE_IDLE : MODE_DROP;
            cnt_next  = 2'd0;
            acc_next  = 16'h0000;
        end else if (last && (mode_next == MODE_STR || mode_next == MODE_ESC ||
                              mode_next == MODE_HEX)) begin
            cmd_c.ended = has_main;
            mode_next   = MODE_IDLE;
            cnt_next    = 2'd0;
            acc_next    = 16'h0000;
            if (!has_main) begin
                has_main = 1'b1;
            end
        end
    end

    assign cmd  = cmd_c;
    assign push = accept && has_main;

    // Hold scan state, advance on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= 2'd0;
            acc_reg  <= 16'h0000;
        end else if (accept) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/jsu_queue.sv */
`default_nettype none

module jsu_queue #(
    parameter int Depth = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jsu_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output jsu_pkg::cmd_t      head_cmd,
    output jsu_pkg::q_status_t status
);
    import jsu_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    cmd_t            entries [Depth];
    logic [PtrW-1:0] wr_reg, wr_next;
    logic [PtrW-1:0] rd_reg, rd_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign status.full  = (cnt_reg == CntW'(Depth));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entries[rd_reg];

    // Advance pointers with wrap at the last entry
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PtrW'(Depth - 1)) ? '0 : wr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PtrW'(Depth - 1)) ? '0 : rd_reg + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CntW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries[wr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/jsu_back.sv */
`default_nettype none

module jsu_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire jsu_pkg::cmd_t      head_cmd,
    input  wire jsu_pkg::q_status_t status,
    output logic                    pop,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output jsu_pkg::out_item_t      res_word
);
    import jsu_pkg::*;

    logic [1:0] pos_reg, pos_next;
    logic       valid_reg;
    out_item_t  word_reg;

    logic [1:0] n_main;
    logic [1:0] last_idx;
    logic       is_last;
    logic       load;
    out_item_t  cur;

    // Count results of the head command
    always_comb
    begin
        case (head_cmd.op)
            OP_UTF8: n_main = utf8_len(head_cmd.value);
            default: n_main = 2'd1;
        endcase
    end

    assign last_idx = (n_main - 2'd1) + {1'b0, head_cmd.ended};
    assign is_last  = (pos_reg == last_idx);
    assign load     = !status.empty && (!valid_reg || !res_stall);
    assign pop      = load && is_last;

    // Build the result at the current position
    always_comb
    begin
        cur.out_byte    = 8'h00;
        cur.out_kind    = KIND_ERR;
        cur.error_code  = ERR_ENDED;
        cur.last_of_run = is_last;
        if (pos_reg < n_main) begin
            case (head_cmd.op)
                OP_DATA: begin
                    cur.out_byte   = head_cmd.value[7:0];
                    cur.out_kind   = KIND_DATA;
                    cur.error_code = ERR_QUOTE;
                end
                OP_UTF8: begin
                    cur.out_byte   = utf8_byte(head_cmd.value, pos_reg);
                    cur.out_kind   = KIND_DATA;
                    cur.error_code = ERR_QUOTE;
                end
                OP_DONE: begin
                    cur.out_kind   = KIND_DONE;
                    cur.error_code = ERR_QUOTE;
                end
                default: begin
                    cur.error_code = head_cmd.err_code;
                end
            endcase
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (load) begin
            pos_next = is_last ? 2'd0 : pos_reg + 2'd1;
        end
    end

    // Hold the output word while stalled, refill when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (!valid_reg || !res_stall) begin
                valid_reg <= !status.empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            word_reg <= cur;
        end
    end

    assign res_valid = valid_reg;
    assign res_word  = word_reg;

endmodule

`default_nettype wire

/* rtl/core/json_string_unescape_utf8.sv */
// Channel   Signals                                Carries
// --------  -------------------------------------  ------------------------------
// byte      byte_valid, byte_stall, byte_word      one JSON text byte, end flag
// res       res_valid, res_stall, res_word         one decoded byte, marker or error
//
// The front takes one text byte per cycle while the command queue has room.
// Each byte leaves 0 to 4 results; the back end sends one result per cycle while res_stall is low,
// and a \uXXXX escape leaves up to 4 results (3 bytes + error).
// The queue holds QueueDepth commands; byte_stall rises when it is full.
// Reset clears scan state, the queue pointers and the output valid flag.
`default_nettype none

module json_string_unescape_utf8 #(
    parameter int QueueDepth = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire jsu_pkg::in_item_t byte_word,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output jsu_pkg::out_item_t     res_word
);
    import jsu_pkg::*;

    cmd_t      f_cmd;
    logic      f_push;
    cmd_t      q_head;
    q_status_t q_status;
    logic      b_pop;
    logic      accept;

    assign byte_stall = q_status.full;
    assign accept     = byte_valid && !byte_stall;

    jsu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_word (byte_word),
        .cmd     (f_cmd),
        .push    (f_push)
    );

    jsu_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .push_cmd (f_cmd),
        .pop      (b_pop),
        .head_cmd (q_head),
        .status   (q_status)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (q_head),
        .status    (q_status),
        .pop       (b_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    // Finished-string and error results always close a byte's run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.out_kind == KIND_DONE |-> res_word.last_of_run)
        else $error("string end not last of run");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.out_kind == KIND_ERR |-> res_word.last_of_run)
        else $error("error not last of run");

    // Unused fields stay zero
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.out_kind != KIND_ERR |-> res_word.error_code == ERR_QUOTE)
        else $error("error code set on non-error");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.out_kind != KIND_DATA |-> res_word.out_byte == 8'h00)
        else $error("byte set on non-data");

endmodule

`default_nettype wire
